FILE: hdl/lsd_pkg.sv
// Package for the LSD radix sorter: request and status codes, and the
// status bundle that the pass sequencer reports to the top level.
// No dependencies.
`default_nettype none

package lsd_pkg;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // bank is the buffer read as the source of the current pass while busy,
  // and the buffer that holds the sorted batch once done has pulsed.
  typedef struct packed {
    logic busy;
    logic done;
    logic bank;
  } lsd_stat_t;

endpackage

`default_nettype wire

FILE: hdl/lsd_radix_sort_keys_top.sv
// Top level of the LSD radix sorter: request handling, the two item
// buffers, and the result register.
// Depends on lsd_pkg, lsd_ram and lsd_sorter.
//
//   channel | handshake                    | fields
//   --------+------------------------------+---------------------------------------
//   request | in_valid, in_stall           | req_type, sort_key, payload, last_push
//   result  | out_valid, out_stall         | sorted_key, sorted_payload,
//           |                              | last_entry, status
//
// A pop reads the buffer and then loads the result register. A last push
// starts the sort: each pass clears the bucket counters, counts the items
// per bucket, forms the bucket offsets and scatters the items; with 6-bit
// digits and 30-bit keys that is five passes. in_stall is high during a
// sort or a pop, and while a result waits on out_stall. Reset needs no
// clearing pass.
`default_nettype none

module lsd_radix_sort_keys_top #(
  parameter int MAX_ITEMS    = 1024,
  parameter int KEY_BITS     = 30,
  parameter int DIGIT_BITS   = 6,
  parameter int PAYLOAD_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    req_type,
  input  logic [KEY_BITS-1:0]     sort_key,
  input  logic [PAYLOAD_BITS-1:0] payload,
  input  logic                    last_push,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [KEY_BITS-1:0]     sorted_key,
  output logic [PAYLOAD_BITS-1:0] sorted_payload,
  output logic                    last_entry,
  output logic [1:0]              status
);

  import lsd_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int EW = KEY_BITS + PAYLOAD_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_SORT = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] item_count;
  logic [CW-1:0] read_position;
  logic          sorted_ready;
  logic          overflow_seen;
  logic          res_bank;
  logic          pop_last;

  logic          accept;
  logic          is_push;
  logic [CW-1:0] base_count;
  logic          base_ovf;
  logic          has_room;
  logic          push_we;
  logic          push_result;
  logic          pop_ok;
  logic          start_sort;

  lsd_stat_t     stat;
  logic [AW-1:0] srt_raddr;
  logic          srt_we;
  logic [AW-1:0] srt_waddr;
  logic [EW-1:0] srt_wdata;
  logic [EW-1:0] srt_rdata;
  logic [EW-1:0] pop_rdata;

  logic          b0_we, b1_we;
  logic [AW-1:0] b0_waddr, b0_raddr, b1_raddr;
  logic [EW-1:0] b0_wdata;
  logic [EW-1:0] b0_rdata, b1_rdata;

  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign is_push  = (req_type == REQ_PUSH);

  // The first push after a finished sort opens a new batch.
  assign base_count  = sorted_ready ? '0 : item_count;
  assign base_ovf    = !sorted_ready && overflow_seen;
  assign has_room    = (base_count < CW'(MAX_ITEMS));
  assign push_we     = accept && is_push && has_room;
  assign push_result = !has_room || (last_push && base_ovf);
  assign pop_ok      = sorted_ready && (read_position < item_count);
  assign start_sort  = accept && is_push && last_push;

  // Pushes always fill buffer 0; the sorter then ping-pongs between both.
  assign b0_we    = push_we || (stat.busy && srt_we && stat.bank);
  assign b0_waddr = push_we ? base_count[AW-1:0] : srt_waddr;
  assign b0_wdata = push_we ? {sort_key, payload} : srt_wdata;
  assign b1_we    = stat.busy && srt_we && !stat.bank;
  assign b0_raddr = (stat.busy && !stat.bank) ? srt_raddr : read_position[AW-1:0];
  assign b1_raddr = (stat.busy && stat.bank) ? srt_raddr : read_position[AW-1:0];

  assign srt_rdata = stat.bank ? b1_rdata : b0_rdata;
  assign pop_rdata = res_bank ? b1_rdata : b0_rdata;

  lsd_ram #(
    .DEPTH (MAX_ITEMS),
    .WIDTH (EW)
  ) u_bank0 (
    .clk   (clk),
    .we    (b0_we),
    .waddr (b0_waddr),
    .wdata (b0_wdata),
    .raddr (b0_raddr),
    .rdata (b0_rdata)
  );

  lsd_ram #(
    .DEPTH (MAX_ITEMS),
    .WIDTH (EW)
  ) u_bank1 (
    .clk   (clk),
    .we    (b1_we),
    .waddr (srt_waddr),
    .wdata (srt_wdata),
    .raddr (b1_raddr),
    .rdata (b1_rdata)
  );

  lsd_sorter #(
    .MAX_ITEMS    (MAX_ITEMS),
    .KEY_BITS     (KEY_BITS),
    .DIGIT_BITS   (DIGIT_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_sorter (
    .clk        (clk),
    .rst        (rst),
    .start      (start_sort),
    .item_count (item_count),
    .src_rdata  (srt_rdata),
    .src_raddr  (srt_raddr),
    .dst_we     (srt_we),
    .dst_waddr  (srt_waddr),
    .dst_wdata  (srt_wdata),
    .stat       (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      item_count    <= '0;
      read_position <= '0;
      sorted_ready  <= 1'b0;
      overflow_seen <= 1'b0;
      res_bank      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (is_push) begin
              item_count    <= has_room ? base_count + CW'(1) : base_count;
              overflow_seen <= base_ovf || !has_room;
              sorted_ready  <= 1'b0;
              read_position <= '0;
              if (last_push) state <= ST_SORT;
              if (push_result) begin
                out_valid      <= 1'b1;
                sorted_key     <= '0;
                sorted_payload <= '0;
                last_entry     <= 1'b0;
                status         <= STATUS_OVERFLOW;
              end
            end else if (pop_ok) begin
              read_position <= read_position + CW'(1);
              pop_last      <= ((read_position + CW'(1)) == item_count);
              state         <= ST_POP;
            end else begin
              out_valid      <= 1'b1;
              sorted_key     <= '0;
              sorted_payload <= '0;
              last_entry     <= 1'b0;
              status         <= STATUS_EMPTY;
            end
          end
        end
        ST_POP: begin
          out_valid      <= 1'b1;
          sorted_key     <= pop_rdata[EW-1:PAYLOAD_BITS];
          sorted_payload <= pop_rdata[PAYLOAD_BITS-1:0];
          last_entry     <= pop_last;
          status         <= STATUS_OK;
          state          <= ST_IDLE;
        end
        ST_SORT: begin
          if (stat.done) begin
            sorted_ready <= 1'b1;
            res_bank     <= stat.bank;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_count <= CW'(MAX_ITEMS))
    else $error("item count beyond capacity");

  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    sorted_ready |-> read_position <= item_count)
    else $error("read position past the sorted batch");

  a_done_in_sort: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == ST_SORT)
    else $error("sort completion outside a sort");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_OK) |->
      (sorted_key == '0 && sorted_payload == '0 && !last_entry))
    else $error("error result carries non-zero fields");

endmodule

`default_nettype wire

FILE: hdl/lsd_ram.sv
// Simple dual-port RAM: one write port and one read port with registered
// read data. Used for both item buffers and for the bucket counters.
// No dependencies.
`default_nettype none

module lsd_ram #(
  parameter int  DEPTH = 64,
  parameter int  WIDTH = 8,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/lsd_sorter.sv
// Pass sequencer of the radix sorter: clear, count, prefix and scatter over
// the bucket counter RAM; count, prefix and scatter share one adder.
// Depends on lsd_pkg and lsd_ram.
`default_nettype none

module lsd_sorter #(
  parameter int  MAX_ITEMS    = 1024,
  parameter int  KEY_BITS     = 30,
  parameter int  DIGIT_BITS   = 6,
  parameter int  PAYLOAD_BITS = 20,
  localparam int AW           = $clog2(MAX_ITEMS),
  localparam int CW           = $clog2(MAX_ITEMS + 1),
  localparam int EW           = KEY_BITS + PAYLOAD_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CW-1:0]     item_count,
  input  logic [EW-1:0]     src_rdata,
  output logic [AW-1:0]     src_raddr,
  output logic              dst_we,
  output logic [AW-1:0]     dst_waddr,
  output logic [EW-1:0]     dst_wdata,
  output lsd_pkg::lsd_stat_t stat
);

  import lsd_pkg::*;

  localparam int NB         = 1 << DIGIT_BITS;
  localparam int NUM_PASSES = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PW         = (NUM_PASSES > 1) ? $clog2(NUM_PASSES) : 1;
  localparam int PADW       = NUM_PASSES * DIGIT_BITS;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CLEAR   = 3'd1;
  localparam logic [2:0] S_COUNT   = 3'd2;
  localparam logic [2:0] S_PREFIX  = 3'd3;
  localparam logic [2:0] S_SCATTER = 3'd4;

  logic [2:0]            state;
  logic [2:0]            state_next;
  logic [CW-1:0]         idx;
  logic [PW-1:0]         pass;
  logic                  src_bank;
  logic [DIGIT_BITS-1:0] bkt;
  logic                  bdone;
  logic [CW-1:0]         running;
  logic                  done;

  // Sweep pipeline: stage 1 has the item read back, stage 2 the bucket
  // count; stage 3 remembers the last counter write for forwarding.
  logic                  v1, v2, v3;
  logic [DIGIT_BITS-1:0] d2, d3;
  logic [EW-1:0]         e2;
  logic [CW-1:0]         w3;
  logic                  pv1;
  logic [DIGIT_BITS-1:0] pb1;

  logic                  sweep;
  logic                  issue;
  logic                  sweep_end;
  logic                  prefix_end;
  logic                  last_pass;
  logic [PADW-1:0]       key_pad;
  logic [DIGIT_BITS-1:0] digit1;
  logic [CW-1:0]         fwd;
  logic [CW-1:0]         add_a;
  logic [CW-1:0]         add_b;
  logic [CW-1:0]         sum;

  logic                  c_we;
  logic [DIGIT_BITS-1:0] c_waddr;
  logic [CW-1:0]         c_wdata;
  logic [DIGIT_BITS-1:0] c_raddr;
  logic [CW-1:0]         c_rdata;

  lsd_ram #(
    .DEPTH (NB),
    .WIDTH (CW)
  ) u_counts (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  assign sweep      = (state == S_COUNT) || (state == S_SCATTER);
  assign issue      = sweep && (idx < item_count);
  assign sweep_end  = sweep && !issue && !v1 && !v2;
  assign prefix_end = (state == S_PREFIX) && bdone && !pv1;
  assign last_pass  = (pass == PW'(NUM_PASSES - 1));

  assign src_raddr = idx[AW-1:0];
  assign key_pad   = PADW'(src_rdata[EW-1:PAYLOAD_BITS]);
  assign digit1    = key_pad[int'(pass) * DIGIT_BITS +: DIGIT_BITS];

  // The counter written in the previous cycle is not yet visible in the
  // RAM read data, so take it from the forwarding register instead.
  assign fwd = (v3 && (d3 == d2)) ? w3 : c_rdata;

  // Shared adder: running offset plus count in the prefix phase,
  // counter increment in the count and scatter phases.
  always_comb begin
    if (state == S_PREFIX) begin
      add_a = running;
      add_b = c_rdata;
    end else begin
      add_a = fwd;
      add_b = CW'(1);
    end
  end
  assign sum = add_a + add_b;

  always_comb begin
    c_raddr = (state == S_PREFIX) ? bkt : digit1;
    case (state)
      S_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = bkt;
        c_wdata = '0;
      end
      S_PREFIX: begin
        c_we    = pv1;
        c_waddr = pb1;
        c_wdata = running;
      end
      S_COUNT, S_SCATTER: begin
        c_we    = v2;
        c_waddr = d2;
        c_wdata = sum;
      end
      default: begin
        c_we    = 1'b0;
        c_waddr = bkt;
        c_wdata = '0;
      end
    endcase
  end

  assign dst_we    = (state == S_SCATTER) && v2;
  assign dst_waddr = fwd[AW-1:0];
  assign dst_wdata = e2;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_CLEAR;
      end
      S_CLEAR: begin
        if (bkt == {DIGIT_BITS{1'b1}}) state_next = S_COUNT;
      end
      S_COUNT: begin
        if (sweep_end) state_next = S_PREFIX;
      end
      S_PREFIX: begin
        if (prefix_end) state_next = S_SCATTER;
      end
      S_SCATTER: begin
        if (sweep_end) state_next = last_pass ? S_IDLE : S_CLEAR;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      pv1      <= 1'b0;
      pass     <= '0;
      src_bank <= 1'b0;
      bkt      <= '0;
      bdone    <= 1'b0;
      idx      <= '0;
      running  <= '0;
    end else begin
      state <= state_next;
      done  <= (state == S_SCATTER) && sweep_end && last_pass;
      v1    <= issue;
      v2    <= v1;
      v3    <= v2;
      pv1   <= (state == S_PREFIX) && !bdone;
      case (state)
        S_IDLE: begin
          if (start) begin
            pass     <= '0;
            src_bank <= 1'b0;
            bkt      <= '0;
          end
        end
        S_CLEAR: begin
          bkt <= bkt + 1'b1;
          idx <= '0;
        end
        S_COUNT: begin
          if (issue) idx <= idx + 1'b1;
          if (sweep_end) begin
            bkt     <= '0;
            bdone   <= 1'b0;
            running <= '0;
          end
        end
        S_PREFIX: begin
          if (!bdone) begin
            bkt <= bkt + 1'b1;
            if (bkt == {DIGIT_BITS{1'b1}}) bdone <= 1'b1;
          end
          if (pv1) running <= sum;
          if (prefix_end) idx <= '0;
        end
        S_SCATTER: begin
          if (issue) idx <= idx + 1'b1;
          if (sweep_end) begin
            src_bank <= ~src_bank;
            bkt      <= '0;
            if (!last_pass) pass <= pass + 1'b1;
          end
        end
        default: begin
          bkt <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    d2  <= digit1;
    e2  <= src_rdata;
    d3  <= d2;
    w3  <= sum;
    pb1 <= bkt;
  end

  assign stat.busy = (state != S_IDLE);
  assign stat.done = done;
  assign stat.bank = src_bank;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE)
    else $error("sort started while a sort is running");

  a_prefix_total: assert property (@(posedge clk) disable iff (rst)
    prefix_end |-> running == item_count)
    else $error("bucket counts do not add up to the item count");

  a_dst_range: assert property (@(posedge clk) disable iff (rst)
    dst_we |-> fwd < item_count)
    else $error("scatter position beyond the stored items");

endmodule

`default_nettype wire

FILE: dv/tb_lsd_radix_sort_keys_top.sv
// Self-checking testbench for lsd_radix_sort_keys_top: batches of keys are pushed, sorted and
// popped, and every result is checked against a stable sort of the same batch held here.
// Depends on lsd_pkg and the sorter RTL.
`timescale 1ns / 100ps

module tb_lsd_radix_sort_keys_top;
  import lsd_pkg::*;

  localparam int KEY_W       = 30;
  localparam int PAY_W       = 20;
  localparam int DIGIT_W     = 6;
  localparam int NUM_DIGITS  = 5;
  localparam int CAPACITY    = 1024;
  localparam int LONG_HOLD   = 3000;
  localparam int QUIET_LIMIT = 60000;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam logic [PAY_W-1:0] PAY_MAX = '1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
  } entry_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
    logic             last;
    logic [1:0]       status;
  } result_t;

  typedef struct packed {
    logic             req;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
    logic             last;
  } request_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             req_type = REQ_PUSH;
  logic [KEY_W-1:0] sort_key = '0;
  logic [PAY_W-1:0] payload = '0;
  logic             last_push = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [KEY_W-1:0] sorted_key;
  logic [PAY_W-1:0] sorted_payload;
  logic             last_entry;
  logic [1:0]       status;

  request_t request_queue[$];
  result_t  due_results[$];

  // Sorter state as seen from outside: the current batch (sorted in place once the
  // last push arrives) and the read pointer into it.
  entry_t   batch[$];
  int       read_pos = 0;
  bit       batch_sorted = 1'b0;
  bit       batch_overflowed = 1'b0;

  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       long_hold_req = 1'b0;
  int       hold_left = 0;
  int       items_queued = 0;
  int       fail_count = 0;
  int       quiet_cycles = 0;

  lsd_radix_sort_keys_top #(
    .MAX_ITEMS    (CAPACITY),
    .KEY_BITS     (KEY_W),
    .DIGIT_BITS   (DIGIT_W),
    .PAYLOAD_BITS (PAY_W)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .sort_key       (sort_key),
    .payload        (payload),
    .last_push      (last_push),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sorted_key     (sorted_key),
    .sorted_payload (sorted_payload),
    .last_entry     (last_entry),
    .status         (status)
  );

  always #5 clk = ~clk;

  // Stable insertion sort: an entry goes after every entry whose key is not greater.
  function automatic void order_batch_by_key();
    entry_t ranked[$];
    int     j;
    foreach (batch[i]) begin
      j = ranked.size();
      while (j > 0 && ranked[j-1].key > batch[i].key) j--;
      ranked.insert(j, batch[i]);
    end
    batch = ranked;
  endfunction

  function automatic void apply_request(logic req, logic [KEY_W-1:0] k,
                                        logic [PAY_W-1:0] p, logic l);
    result_t res;
    entry_t  ent;
    bit      dropped;
    res = '0;
    dropped = 1'b0;
    if (req == REQ_PUSH) begin
      // The first push after a finished sort opens a fresh batch.
      if (batch_sorted) begin
        batch.delete();
        read_pos = 0;
        batch_sorted = 1'b0;
        batch_overflowed = 1'b0;
      end
      if (batch.size() < CAPACITY) begin
        ent.key = k;
        ent.pay = p;
        batch.insert(batch.size(), ent);
      end else begin
        dropped = 1'b1;
        batch_overflowed = 1'b1;
      end
      if (l) begin
        order_batch_by_key();
        read_pos = 0;
        batch_sorted = 1'b1;
      end
      if (dropped || (l && batch_overflowed)) begin
        res.status = STATUS_OVERFLOW;
        due_results.insert(due_results.size(), res);
      end
    end else if (!batch_sorted || read_pos >= batch.size()) begin
      res.status = STATUS_EMPTY;
      due_results.insert(due_results.size(), res);
    end else begin
      res.key = batch[read_pos].key;
      res.pay = batch[read_pos].pay;
      res.last = (read_pos + 1 == batch.size());
      res.status = STATUS_OK;
      due_results.insert(due_results.size(), res);
      read_pos++;
    end
  endfunction

  task automatic check_result();
    result_t want;
    if (due_results.size() == 0) begin
      $error("unexpected result: key %h payload %h last %0d status %0d",
             sorted_key, sorted_payload, last_entry, status);
      fail_count++;
    end else begin
      want = due_results.pop_front();
      if (sorted_key !== want.key) begin
        $error("sorted_key: expected %h, got %h", want.key, sorted_key);
        fail_count++;
      end
      if (sorted_payload !== want.pay) begin
        $error("sorted_payload: expected %h, got %h", want.pay, sorted_payload);
        fail_count++;
      end
      if (last_entry !== want.last) begin
        $error("last_entry: expected %0d, got %0d", want.last, last_entry);
        fail_count++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        fail_count++;
      end
    end
  endtask

  // Request driver: a stalled transaction is held unchanged until it is taken.
  always @(posedge clk) begin : drive_requests
    request_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = request_queue.pop_front();
        in_valid  <= 1'b1;
        req_type  <= nxt.req;
        sort_key  <= nxt.key;
        payload   <= nxt.pay;
        last_push <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (long_hold_req) begin
        hold_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Results are checked before the request of the same edge is predicted; a result
  // can never stem from a transaction accepted at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) apply_request(req_type, sort_key, payload, last_push);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic enqueue(logic req, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p, logic l);
    request_t r;
    r.req = req;
    r.key = k;
    r.pay = p;
    r.last = l;
    request_queue.insert(request_queue.size(), r);
    items_queued++;
  endtask

  function automatic logic [PAY_W-1:0] rand_pay();
    logic [31:0] w;
    w = $urandom();
    return w[PAY_W-1:0];
  endfunction

  // Key styles: fully random, a handful of small values (many ties), one digit
  // varied around a common base, and the corner values.
  function automatic logic [KEY_W-1:0] pick_key(int style, logic [KEY_W-1:0] base);
    logic [31:0]      w;
    logic [KEY_W-1:0] d;
    w = $urandom();
    d = w[DIGIT_W-1:0];
    case (style)
      0: return w[KEY_W-1:0];
      1: return KEY_W'($urandom_range(7));
      2: return base ^ (d << (DIGIT_W * $urandom_range(NUM_DIGITS - 1)));
      default: begin
        case ($urandom_range(3))
          0: return '0;
          1: return KEY_MAX;
          2: return KEY_W'(1) << (KEY_W - 1);
          default: return KEY_W'(1) << (DIGIT_W * $urandom_range(NUM_DIGITS - 1));
        endcase
      end
    endcase
  endfunction

  task automatic push_item(logic [KEY_W-1:0] k, logic [PAY_W-1:0] p, logic l);
    enqueue(REQ_PUSH, k, p, l);
  endtask

  // Pops carry random junk in the unused fields.
  task automatic pop_item();
    enqueue(REQ_POP, pick_key(0, '0), rand_pay(), 1'($urandom_range(1)));
  endtask

  task automatic queue_batch(int n, int pops);
    int               style;
    logic [KEY_W-1:0] base;
    style = $urandom_range(3);
    base = pick_key(0, '0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) pop_item();
      push_item(pick_key(($urandom_range(4) == 0) ? $urandom_range(3) : style, base),
                rand_pay(), i == n - 1);
    end
    repeat (pops) pop_item();
  endtask

  task automatic run_random(int n_items);
    int first;
    int n;
    first = items_queued;
    while (items_queued - first < n_items) begin
      if ($urandom_range(9) < 8) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(64, 200) : $urandom_range(1, 24);
        // Mostly read the whole batch and a little past it; sometimes abandon it.
        queue_batch(n, ($urandom_range(4) == 0) ? $urandom_range(n) : n + $urandom_range(2));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(1)) pop_item();
          else push_item(pick_key(0, '0), rand_pay(), $urandom_range(3) == 0);
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (request_queue.size() != 0 || in_valid || due_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part.
    pop_item();
    push_item(KEY_MAX, '0, 1'b0);
    push_item('0, PAY_MAX, 1'b0);
    push_item(KEY_W'(1) << (KEY_W - 1), PAY_W'(1), 1'b0);
    push_item('0, PAY_W'(5), 1'b0);
    pop_item();
    push_item(KEY_W'(63), PAY_W'(2), 1'b0);
    push_item(KEY_W'(64), PAY_W'(3), 1'b0);
    push_item(KEY_MAX, PAY_MAX, 1'b1);
    repeat (4) pop_item();
    push_item(30'h1555_5555, 20'hAAAAA, 1'b1);
    repeat (3) pop_item();
    wait_drained();

    // Fill to capacity, overflow with one push, then a dropped last push.
    for (int i = 0; i < CAPACITY; i++)
      push_item(pick_key($urandom_range(3), 30'h2AAA_AAAA), rand_pay(), 1'b0);
    push_item(pick_key(0, '0), rand_pay(), 1'b0);
    push_item(pick_key(0, '0), rand_pay(), 1'b1);
    repeat (4) pop_item();
    wait_drained();

    // The receiver holds off while pops keep coming, so the block backs up.
    queue_batch(16, 0);
    wait_drained();
    long_hold_req = 1'b1;
    repeat (18) pop_item();
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(25);
    wait_drained();
    send_idle_pct = 50;
    run_random(25);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 50;
    run_random(25);
    wait_drained();
    send_idle_pct = 35;
    recv_stall_pct = 35;
    run_random(25);
    wait_drained();

    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/lsd_pkg.sv
hdl/lsd_ram.sv
hdl/lsd_sorter.sv
hdl/lsd_radix_sort_keys_top.sv
dv/tb_lsd_radix_sort_keys_top.sv
